[src/mlpq_pkg.sv]
// Shared types and constants of the multilevel priority FIFO.
// Depends on nothing; every other file of the block uses it.

package mlpq_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned LEVELS_DEF   = 10;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned TAG_BITS_DEF = 32;

  // Fixed field widths of the word format.
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_REMOVED   = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_BAD_LEVEL = 3'd4
  } status_e;

  // Operation as classified by the front end.
  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_BAD_LEVEL = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [LEVEL_W-1:0] level;
  } item_ctrl_t;

endpackage

[src/mlpq_if.sv]
// Valid/ready channel interfaces for the request and result words.
// Depends on mlpq_pkg for the field widths.

interface mlpq_in_if #(
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [mlpq_pkg::LEVEL_W-1:0] level;
  logic [TAG_BITS-1:0]          tag;

  modport source (output valid, output command, output level, output tag, input ready);
  modport sink   (input valid, input command, input level, input tag, output ready);
endinterface

interface mlpq_out_if #(
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [mlpq_pkg::STATUS_W-1:0] status;
  logic [mlpq_pkg::LEVEL_W-1:0]  out_level;
  logic [TAG_BITS-1:0]           out_tag;

  modport source (output valid, output status, output out_level, output out_tag, input ready);
  modport sink   (input valid, input status, input out_level, input out_tag, output ready);
endinterface

[src/mlpq_front.sv]
// Front end: accepts request words and classifies them into operations.
// Depends on mlpq_pkg and mlpq_in_if.

module mlpq_front #(
  parameter int unsigned LEVELS   = mlpq_pkg::LEVELS_DEF,
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
) (
  mlpq_in_if.sink                 in_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output mlpq_pkg::item_ctrl_t    push_ctrl_o,
  output logic [TAG_BITS-1:0]     push_tag_o
);
  import mlpq_pkg::*;

  logic level_bad;

  // An insert with a level at or above the number of levels is rejected; a remove ignores the level.
  assign level_bad = {1'b0, in_i.level} >= (LEVEL_W + 1)'(LEVELS);

  always_comb begin
    push_ctrl_o.level = in_i.level;
    if (in_i.command == CMD_REMOVE) begin
      push_ctrl_o.op = OP_REMOVE;
    end else if (level_bad) begin
      push_ctrl_o.op = OP_BAD_LEVEL;
    end else begin
      push_ctrl_o.op = OP_INSERT;
    end
  end

  assign push_tag_o   = in_i.tag;
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

[src/mlpq_queue.sv]
// Two-entry queue that decouples the front end from the list engine.
// Depends on mlpq_pkg only through the caller's data width.

module mlpq_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import mlpq_pkg::*;

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push_fire ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_fire ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_fire) - 2'(pop_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/mlpq_back.sv]
// List engine: node pool, free list, per-level FIFO lists and result register.
// Depends on mlpq_pkg and mlpq_out_if.

module mlpq_back #(
  parameter int unsigned LEVELS   = mlpq_pkg::LEVELS_DEF,
  parameter int unsigned CAPACITY = mlpq_pkg::CAPACITY_DEF,
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  mlpq_pkg::item_ctrl_t pop_ctrl_i,
  input  logic [TAG_BITS-1:0]  pop_tag_i,
  mlpq_out_if.source           out_o
);
  import mlpq_pkg::*;

  localparam int unsigned NODE_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned LVL_IDX_W = $clog2(LEVELS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_REM  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [LEVELS-1:0]      nonempty_q, nonempty_d;
  logic [NODE_W-1:0]      free_head_q, free_head_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       fresh_q, fresh_d;
  logic                   out_valid_q, out_valid_d;

  logic [NODE_W-1:0]      link_mem [CAPACITY];
  logic [TAG_BITS-1:0]    tag_mem  [CAPACITY];
  logic [NODE_W-1:0]      link_rd_q;
  logic [TAG_BITS-1:0]    tag_rd_q;
  logic [NODE_W-1:0]      head_q [LEVELS];
  logic [NODE_W-1:0]      tail_q [LEVELS];
  logic [NODE_W-1:0]      node_q;
  logic [LVL_IDX_W-1:0]   lvl_q;
  status_e                out_status_q;
  logic [LEVEL_W-1:0]     out_level_q;
  logic [TAG_BITS-1:0]    out_tag_q;

  logic                   pop_fire;
  logic                   out_free;
  logic [LVL_IDX_W-1:0]   pop_lvl;
  logic [LVL_IDX_W-1:0]   pick_lvl;
  logic                   pick_found;
  logic                   pool_full;
  logic [NODE_W-1:0]      next_node;
  logic [NODE_W-1:0]      link_val;

  logic                   rd_en;
  logic                   tag_we;
  logic [NODE_W-1:0]      rd_addr;
  logic                   link_we;
  logic [NODE_W-1:0]      link_waddr;
  logic [NODE_W-1:0]      link_wdata;
  logic                   head_we;
  logic [NODE_W-1:0]      head_wdata;
  logic                   tail_we;
  logic                   res_load;
  status_e                res_status;
  logic [LEVEL_W-1:0]     res_level;
  logic [TAG_BITS-1:0]    res_tag;

  assign out_free    = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign pop_lvl     = pop_ctrl_i.level[LVL_IDX_W-1:0];
  assign pool_full   = (used_q == CNT_W'(CAPACITY));

  // Lowest-numbered non-empty level wins.
  always_comb begin
    pick_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        pick_lvl = LVL_IDX_W'(i);
      end
    end
  end
  assign pick_found = |nonempty_q;

  // Nodes at or above the fresh mark were never linked; their link is still
  // the reset chain, so it is formed here instead of read from the memory.
  assign next_node = (node_q == NODE_W'(CAPACITY - 1)) ? '0 : node_q + 1'b1;
  assign link_val  = (CNT_W'(node_q) >= fresh_q) ? next_node : link_rd_q;

  always_comb begin
    state_d     = state_q;
    nonempty_d  = nonempty_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    fresh_d     = fresh_q;
    rd_en       = 1'b0;
    tag_we      = 1'b0;
    rd_addr     = free_head_q;
    link_we     = 1'b0;
    link_waddr  = node_q;
    link_wdata  = free_head_q;
    head_we     = 1'b0;
    head_wdata  = node_q;
    tail_we     = 1'b0;
    res_load    = 1'b0;
    res_status  = STATUS_INSERTED;
    res_level   = '0;
    res_tag     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_fire) begin
          unique case (pop_ctrl_i.op)
            OP_INSERT: begin
              if (pool_full) begin
                res_load   = 1'b1;
                res_status = STATUS_FULL;
              end else begin
                // Store the tag now and fetch the next free node.
                rd_en   = 1'b1;
                tag_we  = 1'b1;
                rd_addr = free_head_q;
                state_d = ST_INS;
              end
            end
            OP_REMOVE: begin
              if (!pick_found) begin
                res_load   = 1'b1;
                res_status = STATUS_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q[pick_lvl];
                state_d = ST_REM;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = STATUS_BAD_LEVEL;
            end
          endcase
        end
      end
      ST_INS: begin
        free_head_d = link_val;
        if (nonempty_q[lvl_q]) begin
          link_we    = 1'b1;
          link_waddr = tail_q[lvl_q];
          link_wdata = node_q;
        end else begin
          head_we           = 1'b1;
          head_wdata        = node_q;
          nonempty_d[lvl_q] = 1'b1;
        end
        tail_we = 1'b1;
        used_d  = used_q + 1'b1;
        if (CNT_W'(node_q) == fresh_q) begin
          fresh_d = fresh_q + 1'b1;
        end
        res_load   = 1'b1;
        res_status = STATUS_INSERTED;
        state_d    = ST_IDLE;
      end
      ST_REM: begin
        if (node_q == tail_q[lvl_q]) begin
          nonempty_d[lvl_q] = 1'b0;
        end else begin
          head_we    = 1'b1;
          head_wdata = link_rd_q;
        end
        // The freed node goes to the front of the free list.
        link_we     = 1'b1;
        link_waddr  = node_q;
        link_wdata  = free_head_q;
        free_head_d = node_q;
        used_d      = used_q - 1'b1;
        res_load    = 1'b1;
        res_status  = STATUS_REMOVED;
        res_level   = LEVEL_W'(lvl_q);
        res_tag     = tag_rd_q;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nonempty_q  <= '0;
      free_head_q <= '0;
      used_q      <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Node pool memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr];
      tag_rd_q  <= tag_mem[rd_addr];
    end
    if (tag_we) begin
      tag_mem[free_head_q] <= pop_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      node_q <= (pop_ctrl_i.op == OP_INSERT) ? free_head_q : head_q[pick_lvl];
      lvl_q  <= (pop_ctrl_i.op == OP_INSERT) ? pop_lvl : pick_lvl;
    end
    if (head_we) begin
      head_q[lvl_q] <= head_wdata;
    end
    if (tail_we) begin
      tail_q[lvl_q] <= node_q;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_level_q  <= res_level;
      out_tag_q    <= res_tag;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_level = out_level_q;
  assign out_o.out_tag   = out_tag_q;

endmodule

[src/multilevel_priority_fifo.sv]
// Top level of the multilevel priority FIFO: front end, queue and list engine.
// Depends on mlpq_pkg, mlpq_if, mlpq_front, mlpq_queue and mlpq_back.

// The block keeps LEVELS priority levels, each a FIFO of entries linked in a
// shared pool of CAPACITY nodes. An insert word appends its tag at the tail of
// its level; a remove word takes the head of the lowest-numbered non-empty
// level and returns its tag and level. Every request word gives exactly one
// result word, in order. A bad level, a full pool or an empty queue is
// reported in the status and changes nothing. The list engine works on one
// word at a time: an insert or a remove reads the link memory in the idle
// state and writes it and the head and tail tables in its insert or remove
// state; a rejected word is answered from idle. A two-word queue sits between
// the front end and the engine, and the result sits in its own register, so
// requests keep being accepted, until the queue is full, while a result waits
// to be taken. There is no clearing pass after reset: a fresh-node mark
// stands in for the initial free-list chain, so the block is ready at once.

module multilevel_priority_fifo #(
  parameter int unsigned LEVELS   = mlpq_pkg::LEVELS_DEF,
  parameter int unsigned CAPACITY = mlpq_pkg::CAPACITY_DEF,
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlpq_in_if.sink    in_i,
  mlpq_out_if.source out_o
);
  import mlpq_pkg::*;

  // Queue word: classified control followed by the tag.
  localparam int unsigned CTRL_W = $bits(item_ctrl_t);
  localparam int unsigned DATA_W = CTRL_W + TAG_BITS;

  logic                push_valid;
  logic                push_ready;
  item_ctrl_t          push_ctrl;
  logic [TAG_BITS-1:0] push_tag;
  logic                pop_valid;
  logic                pop_ready;
  logic [DATA_W-1:0]   pop_data;
  item_ctrl_t          pop_ctrl;

  mlpq_front #(
    .LEVELS   (LEVELS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctrl_o  (push_ctrl),
    .push_tag_o   (push_tag)
  );

  mlpq_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_ctrl, push_tag}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_ctrl = item_ctrl_t'(pop_data[DATA_W-1 -: CTRL_W]);

  mlpq_back #(
    .LEVELS   (LEVELS),
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_ctrl_i  (pop_ctrl),
    .pop_tag_i   (pop_data[TAG_BITS-1:0]),
    .out_o       (out_o)
  );

endmodule

[src/mlpq_checker.sv]
// Port-level checks of the multilevel priority FIFO, bound to its top level.
// Depends on mlpq_pkg and multilevel_priority_fifo.

module mlpq_checker #(
  parameter int unsigned LEVELS   = mlpq_pkg::LEVELS_DEF,
  parameter int unsigned TAG_BITS = mlpq_pkg::TAG_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [mlpq_pkg::STATUS_W-1:0]   out_status_i,
  input logic [mlpq_pkg::LEVEL_W-1:0]    out_level_i,
  input logic [TAG_BITS-1:0]             out_tag_i
);
  import mlpq_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [2:0] pending_q, pending_d;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign pending_d = pending_q + 3'(in_fire) - 3'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A result word is only delivered for a request word that is still owed one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> pending_q != 3'd0)
    else $error("result word without a pending request word");

  // A result that is held back stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_level_i) && $stable(out_tag_i))
    else $error("stalled result word changed");

  // Only a removal carries a level and a tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != STATUS_REMOVED |->
      out_level_i == '0 && out_tag_i == '0)
    else $error("non-removal result carries level or tag");

  // A removed entry always comes from an existing level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STATUS_REMOVED |->
      {1'b0, out_level_i} < (LEVEL_W + 1)'(LEVELS))
    else $error("removed entry reports a level out of range");

endmodule

bind multilevel_priority_fifo mlpq_checker #(
  .LEVELS   (LEVELS),
  .TAG_BITS (TAG_BITS)
) u_mlpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_level_i  (out_o.out_level),
  .out_tag_i    (out_o.out_tag)
);
